@@ hdl/bracket_loop_tape_machine_top_assert.svh @@
// ----------------------------------------------------------------------------
// bracket loop tape machine assertion macros
// concurrent property wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef BRACKET_LOOP_TAPE_MACHINE_TOP_ASSERT_SVH
`define BRACKET_LOOP_TAPE_MACHINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blt check failed");
`define BLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blt check failed");
`else
`define BLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/blt_pkg.sv @@
// ----------------------------------------------------------------------------
// blt_pkg
// shared constants, codes and port structs of the bracket loop tape machine
// ----------------------------------------------------------------------------
package blt_pkg;

  localparam int TAPE_CELLS  = 32768;
  localparam int CODE_DEPTH  = 4096;
  localparam int STACK_DEPTH = 64;
  localparam int CELL_BITS   = 32;

  localparam int TAPE_AW  = $clog2(TAPE_CELLS);
  localparam int CODE_AW  = $clog2(CODE_DEPTH);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int PC_W     = CODE_AW + 1;
  localparam int LVL_W    = STACK_AW + 1;

  localparam logic [7:0] SYM_INC   = 8'h2B;
  localparam logic [7:0] SYM_DEC   = 8'h2D;
  localparam logic [7:0] SYM_RIGHT = 8'h3E;
  localparam logic [7:0] SYM_LEFT  = 8'h3C;
  localparam logic [7:0] SYM_OUT   = 8'h2E;
  localparam logic [7:0] SYM_IN    = 8'h2C;
  localparam logic [7:0] SYM_OPEN  = 8'h5B;
  localparam logic [7:0] SYM_CLOSE = 8'h5D;

  typedef logic [PC_W-1:0]      pc_t;
  typedef logic [TAPE_AW-1:0]   cp_t;
  typedef logic [LVL_W-1:0]     lvl_t;
  typedef logic [CELL_BITS-1:0] cell_t;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_RESTART = 2'd2,
    OP_STEP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNMATCHED = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_FULL      = 3'd4
  } st_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic               we;
    logic [CODE_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic [CODE_AW-1:0] raddr;
  } prog_port_t;

  typedef struct packed {
    logic  we;
    cp_t   waddr;
    cell_t wdata;
    cp_t   raddr;
  } tape_port_t;

  typedef struct packed {
    logic                we;
    logic [STACK_AW-1:0] waddr;
    logic [CODE_AW-1:0]  wdata;
    logic [STACK_AW-1:0] raddr;
  } stack_port_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] obyte;
    logic       ovalid;
    logic       took;
    logic       halted;
    st_t        status;
  } res_t;

endpackage

@@ hdl/blt_ram.sv @@
// ----------------------------------------------------------------------------
// blt_ram
// simple dual port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
module blt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/blt_core.sv @@
// ----------------------------------------------------------------------------
// blt_core
// sequencer: reads program, tape and loop stack, updates and writes back
// ----------------------------------------------------------------------------
module blt_core
  import blt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  op_t               in_op,
  input  logic [7:0]        in_code_byte,
  input  logic [7:0]        in_in_byte,
  input  logic              in_in_eof,
  output prog_port_t        prog_port,
  input  logic [7:0]        prog_rdata,
  output tape_port_t        tape_port,
  input  cell_t             tape_rdata,
  output stack_port_t       stack_port,
  input  logic [CODE_AW-1:0] stack_rdata,
  output res_t              res,
  input  logic              res_ready
);

  state_t     state_r, state_nxt;
  pc_t        len_r, len_nxt;
  pc_t        pc_r, pc_nxt;
  cp_t        cp_r, cp_nxt;
  lvl_t       lvl_r, lvl_nxt;
  cp_t        clr_idx_r, clr_idx_nxt;
  logic       clr_emit_r, clr_emit_nxt;
  op_t        op_r, op_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] ibyte_r, ibyte_nxt;
  logic       eof_r, eof_nxt;
  logic       go_r, go_nxt;
  pc_t        scan_r, scan_nxt;
  pc_t        depth_r, depth_nxt;
  res_t       res_r, res_nxt;
  res_t       res_now;
  logic       done;
  pc_t        pc_p1;
  pc_t        scan_p1;
  lvl_t       lvl_m1;

  assign pc_p1   = pc_r + PC_W'(1);
  assign scan_p1 = scan_r + PC_W'(1);
  assign lvl_m1  = lvl_r - LVL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      len_r      <= '0;
      pc_r       <= '0;
      cp_r       <= '0;
      lvl_r      <= '0;
      clr_idx_r  <= '0;
      clr_emit_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      pc_r       <= pc_nxt;
      cp_r       <= cp_nxt;
      lvl_r      <= lvl_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_emit_r <= clr_emit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    code_r  <= code_nxt;
    ibyte_r <= ibyte_nxt;
    eof_r   <= eof_nxt;
    go_r    <= go_nxt;
    scan_r  <= scan_nxt;
    depth_r <= depth_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    pc_nxt       = pc_r;
    cp_nxt       = cp_r;
    lvl_nxt      = lvl_r;
    clr_idx_nxt  = clr_idx_r;
    clr_emit_nxt = clr_emit_r;
    op_nxt       = op_r;
    code_nxt     = code_r;
    ibyte_nxt    = ibyte_r;
    eof_nxt      = eof_r;
    go_nxt       = go_r;
    scan_nxt     = scan_r;
    depth_nxt    = depth_r;
    res_nxt      = res_r;
    done         = 1'b0;

    res_now        = '0;
    res_now.status = ST_OK;

    prog_port.we     = 1'b0;
    prog_port.waddr  = len_r[CODE_AW-1:0];
    prog_port.wdata  = code_r;
    prog_port.raddr  = pc_r[CODE_AW-1:0];
    tape_port.we     = 1'b0;
    tape_port.waddr  = cp_r;
    tape_port.wdata  = '0;
    tape_port.raddr  = cp_r;
    stack_port.we    = 1'b0;
    stack_port.waddr = lvl_r[STACK_AW-1:0];
    stack_port.wdata = pc_r[CODE_AW-1:0];
    stack_port.raddr = lvl_m1[STACK_AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        tape_port.we    = 1'b1;
        tape_port.waddr = clr_idx_r;
        if (clr_idx_r == TAPE_AW'(TAPE_CELLS - 1)) begin
          clr_idx_nxt = '0;
          if (clr_emit_r) begin
            done = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_idx_nxt = clr_idx_r + TAPE_AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          code_nxt  = in_code_byte;
          ibyte_nxt = in_in_byte;
          eof_nxt   = in_in_eof;
          go_nxt    = pc_r < len_r;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_APPEND: begin
            if (len_r < PC_W'(CODE_DEPTH)) begin
              prog_port.we = 1'b1;
              len_nxt      = len_r + PC_W'(1);
            end else begin
              res_now.status = ST_FULL;
            end
            done = 1'b1;
          end
          OP_CLEAR: begin
            len_nxt = '0;
            pc_nxt  = '0;
            lvl_nxt = '0;
            done    = 1'b1;
          end
          OP_RESTART: begin
            pc_nxt       = '0;
            cp_nxt       = '0;
            lvl_nxt      = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end
          OP_STEP: begin
            if (go_r) begin
              done   = 1'b1;
              pc_nxt = pc_p1;
              unique case (prog_rdata)
                SYM_INC: begin
                  tape_port.we    = 1'b1;
                  tape_port.wdata = tape_rdata + CELL_BITS'(1);
                end
                SYM_DEC: begin
                  tape_port.we    = 1'b1;
                  tape_port.wdata = tape_rdata - CELL_BITS'(1);
                end
                SYM_RIGHT: begin
                  cp_nxt = (cp_r == TAPE_AW'(TAPE_CELLS - 1)) ? '0 : cp_r + TAPE_AW'(1);
                end
                SYM_LEFT: begin
                  cp_nxt = (cp_r == '0) ? TAPE_AW'(TAPE_CELLS - 1) : cp_r - TAPE_AW'(1);
                end
                SYM_OUT: begin
                  res_now.obyte  = tape_rdata[7:0];
                  res_now.ovalid = 1'b1;
                end
                SYM_IN: begin
                  tape_port.we    = 1'b1;
                  tape_port.wdata = eof_r ? '1 : CELL_BITS'(ibyte_r);
                  res_now.took    = 1'b1;
                end
                SYM_OPEN: begin
                  if (tape_rdata != '0) begin
                    if (lvl_r < LVL_W'(STACK_DEPTH)) begin
                      stack_port.we = 1'b1;
                      lvl_nxt       = lvl_r + LVL_W'(1);
                    end else begin
                      res_now.status = ST_OVERFLOW;
                    end
                  end else begin
                    done            = 1'b0;
                    pc_nxt          = pc_r;
                    prog_port.raddr = pc_p1[CODE_AW-1:0];
                    scan_nxt        = pc_p1;
                    depth_nxt       = PC_W'(1);
                    state_nxt       = S_SCAN;
                  end
                end
                SYM_CLOSE: begin
                  if (lvl_r == '0) begin
                    res_now.status = ST_UNDERFLOW;
                  end else if (tape_rdata != '0) begin
                    pc_nxt = PC_W'(stack_rdata) + PC_W'(1);
                  end else begin
                    lvl_nxt = lvl_m1;
                  end
                end
                default: begin
                end
              endcase
            end else begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        prog_port.raddr = scan_p1[CODE_AW-1:0];
        scan_nxt        = scan_p1;
        if (scan_r >= len_r) begin
          res_now.status = ST_UNMATCHED;
          pc_nxt         = pc_p1;
          done           = 1'b1;
        end else if (prog_rdata == SYM_OPEN) begin
          depth_nxt = depth_r + PC_W'(1);
        end else if (prog_rdata == SYM_CLOSE) begin
          if (depth_r == PC_W'(1)) begin
            pc_nxt = scan_p1;
            done   = 1'b1;
          end else begin
            depth_nxt = depth_r - PC_W'(1);
          end
        end
      end
      S_WAIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res_now.valid  = done;
    res_now.halted = pc_nxt >= len_nxt;

    if (done) begin
      res_nxt   = res_now;
      state_nxt = res_ready ? S_IDLE : S_WAIT;
    end

    res = (state_r == S_WAIT) ? res_r : res_now;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ hdl/bracket_loop_tape_machine_top.sv @@
// ----------------------------------------------------------------------------
// bracket_loop_tape_machine_top
// Tape machine for the eight-symbol bracket-loop language.
//
// Input channel (in_valid / in_stall) carries one command word: append a
// program byte, clear the program, restart the run or execute one step.
// Output channel (out_valid / out_stall) returns one result word per command.
// An ordinary command reads the program, tape and loop stack memories, then
// writes back. The result then sits in the output register, and a new
// command is taken while it waits.
// A skip over a loop on a zero cell walks the program memory at one byte per
// cycle up to the matching bracket.
// Restart clears the 32768-cell tape one cell per cycle.
// After reset the same tape clearing pass runs with in_stall high; the
// program store and loop stack are not cleared.
// When the receiver stalls, the finished result is held and the sequencer
// waits; in_stall stays high until the result can move on.
// ----------------------------------------------------------------------------
`include "bracket_loop_tape_machine_top_assert.svh"

module bracket_loop_tape_machine_top
  import blt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_code_byte,
  input  logic [7:0] in_in_byte,
  input  logic       in_in_eof,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic       out_out_valid,
  output logic       out_took_input,
  output logic       out_halted,
  output logic [2:0] out_status
);

  prog_port_t         prog_port;
  tape_port_t         tape_port;
  stack_port_t        stack_port;
  logic [7:0]         prog_rdata;
  cell_t              tape_rdata;
  logic [CODE_AW-1:0] stack_rdata;
  res_t               res;
  logic               res_ready;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  blt_ram #(.DEPTH(CODE_DEPTH), .WIDTH(8)) u_prog_ram (
    .clk   (clk),
    .we    (prog_port.we),
    .waddr (prog_port.waddr),
    .wdata (prog_port.wdata),
    .raddr (prog_port.raddr),
    .rdata (prog_rdata)
  );

  blt_ram #(.DEPTH(TAPE_CELLS), .WIDTH(CELL_BITS)) u_tape_ram (
    .clk   (clk),
    .we    (tape_port.we),
    .waddr (tape_port.waddr),
    .wdata (tape_port.wdata),
    .raddr (tape_port.raddr),
    .rdata (tape_rdata)
  );

  blt_ram #(.DEPTH(STACK_DEPTH), .WIDTH(CODE_AW)) u_stack_ram (
    .clk   (clk),
    .we    (stack_port.we),
    .waddr (stack_port.waddr),
    .wdata (stack_port.wdata),
    .raddr (stack_port.raddr),
    .rdata (stack_rdata)
  );

  blt_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (op_t'(in_op)),
    .in_code_byte (in_code_byte),
    .in_in_byte   (in_in_byte),
    .in_in_eof    (in_in_eof),
    .prog_port    (prog_port),
    .prog_rdata   (prog_rdata),
    .tape_port    (tape_port),
    .tape_rdata   (tape_rdata),
    .stack_port   (stack_port),
    .stack_rdata  (stack_rdata),
    .res          (res),
    .res_ready    (res_ready)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_out_byte   = out_res_r.obyte;
  assign out_out_valid  = out_res_r.ovalid;
  assign out_took_input = out_res_r.took;
  assign out_halted     = out_res_r.halted;
  assign out_status     = out_res_r.status;

  `BLT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `BLT_ASSERT_NEXT(a_result_held, clk, rst_n, res.valid && !res_ready, res.valid)
  `BLT_ASSERT_NOW(a_output_word_clean, clk, rst_n, out_valid && out_out_valid, !out_took_input && out_status == ST_OK)

endmodule

@@ tb/tb_bracket_loop_tape_machine_top.sv @@
// ----------------------------------------------------------------------------
// tb_bracket_loop_tape_machine_top
// Self-checking bench for the bracket loop tape machine. Command words are
// mirrored into a behavioral tape machine that predicts each result word.
// Results are compared field by field in order. Stimulus starts with a short
// hand-written program, then moves on to random program load and run
// sequences, nested loops past the stack depth, and random noise. Sender and
// receiver idle at random.
// ----------------------------------------------------------------------------
module tb_bracket_loop_tape_machine_top
  import blt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [8*14-1:0] DEMO_CODE = {
    SYM_IN, SYM_OUT, SYM_INC, SYM_LEFT, SYM_IN, SYM_OUT, SYM_RIGHT,
    SYM_CLOSE, SYM_OPEN, SYM_OUT, SYM_CLOSE, SYM_OPEN, 8'hFF, 8'h00
  };

  typedef struct packed {
    logic [7:0] obyte;
    logic       ovalid;
    logic       took;
    logic       halted;
    st_t        status;
  } step_result_t;

  class step_scoreboard;
    logic [7:0]   code_mem [CODE_DEPTH];
    int unsigned  code_len;
    int unsigned  pc;
    int unsigned  cp;
    int unsigned  level;
    int unsigned  loop_pcs [STACK_DEPTH];
    cell_t        tape [TAPE_CELLS];
    step_result_t pending_results [$];
    int           errors;

    function new();
      code_len = 0;
      errors   = 0;
      wipe_run();
    endfunction

    function void wipe_run();
      foreach (tape[k]) tape[k] = '0;
      pc    = 0;
      cp    = 0;
      level = 0;
    endfunction

    function void note_command(op_t op, logic [7:0] code, logic [7:0] ib, logic eof);
      step_result_t r;
      logic [7:0]   sym;
      cell_t        cur_cell;
      int unsigned  scan;
      int unsigned  depth;
      bit           found;
      r.obyte  = 8'h00;
      r.ovalid = 1'b0;
      r.took   = 1'b0;
      r.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (code_len < CODE_DEPTH) begin
            code_mem[code_len] = code;
            code_len++;
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_CLEAR: begin
          code_len = 0;
          pc       = 0;
          level    = 0;
        end
        OP_RESTART: wipe_run();
        default: begin
          if (pc < code_len) begin
            sym      = code_mem[pc % CODE_DEPTH];
            cur_cell = tape[cp];
            case (sym)
              SYM_INC:   tape[cp] = cur_cell + 1'b1;
              SYM_DEC:   tape[cp] = cur_cell - 1'b1;
              SYM_RIGHT: cp = (cp == TAPE_CELLS - 1) ? 0 : cp + 1;
              SYM_LEFT:  cp = (cp == 0) ? TAPE_CELLS - 1 : cp - 1;
              SYM_OUT: begin
                r.obyte  = cur_cell[7:0];
                r.ovalid = 1'b1;
              end
              SYM_IN: begin
                tape[cp] = eof ? '1 : cell_t'(ib);
                r.took   = 1'b1;
              end
              SYM_OPEN: begin
                if (cur_cell != 0) begin
                  if (level < STACK_DEPTH) begin
                    loop_pcs[level] = pc;
                    level++;
                  end else begin
                    r.status = ST_OVERFLOW;
                  end
                end else begin
                  // walk forward to the matching close bracket
                  depth = 0;
                  found = 1'b0;
                  scan  = pc;
                  while (!found && scan < code_len && scan < CODE_DEPTH) begin
                    if (code_mem[scan] == SYM_OPEN) begin
                      depth++;
                    end else if (code_mem[scan] == SYM_CLOSE) begin
                      depth--;
                      if (depth == 0) found = 1'b1;
                    end
                    if (!found) scan++;
                  end
                  if (found) pc = scan;
                  else r.status = ST_UNMATCHED;
                end
              end
              SYM_CLOSE: begin
                if (level == 0) r.status = ST_UNDERFLOW;
                else if (cur_cell != 0) pc = loop_pcs[level - 1];
                else level--;
              end
              default: ;
            endcase
            pc++;
          end
        end
      endcase
      r.halted = (pc >= code_len);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [7:0] obyte, logic ovalid, logic took, logic halted,
                               logic [2:0] status);
      step_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing actual status %0d",
                 $time, status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        compare_field("out_byte", e.obyte, obyte);
        compare_field("out_valid", e.ovalid, ovalid);
        compare_field("took_input", e.took, took);
        compare_field("halted", e.halted, halted);
        compare_field("status", e.status, status);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_op = 2'd0;
  logic [7:0] in_code_byte = 8'h00;
  logic [7:0] in_in_byte = 8'h00;
  logic       in_in_eof = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_out_valid;
  logic       out_took_input;
  logic       out_halted;
  logic [2:0] out_status;

  step_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int cycle_count = 0;

  bracket_loop_tape_machine_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_code_byte   (in_code_byte),
    .in_in_byte     (in_in_byte),
    .in_in_eof      (in_in_eof),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_out_valid  (out_out_valid),
    .out_took_input (out_took_input),
    .out_halted     (out_halted),
    .out_status     (out_status)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_out_byte, out_out_valid, out_took_input, out_halted, out_status);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic rand_eof();
    return ($urandom_range(4) == 0);
  endfunction

  task automatic send_word(op_t op, logic [7:0] code, logic [7:0] ib, logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_code_byte <= code;
    in_in_byte   <= ib;
    in_in_eof    <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(op, code, ib, eof);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_symbol();
    int r;
    r = $urandom_range(19);
    if (r < 5) return SYM_INC;
    if (r < 7) return SYM_DEC;
    if (r < 9) return SYM_RIGHT;
    if (r < 10) return SYM_LEFT;
    if (r < 12) return SYM_OUT;
    if (r < 13) return SYM_IN;
    if (r < 15) return SYM_OPEN;
    if (r < 17) return SYM_CLOSE;
    return rand_byte();
  endfunction

  task automatic program_episode();
    int         len;
    int         opens;
    int         i;
    int         steps;
    logic [7:0] b;
    if ($urandom_range(4) != 0) send_word(OP_CLEAR, rand_byte(), rand_byte(), rand_eof());
    len   = $urandom_range(3, 24);
    opens = 0;
    for (i = 0; i < len; i++) begin
      b = pick_symbol();
      if (b == SYM_CLOSE && opens == 0 && $urandom_range(3) != 0) b = SYM_INC;
      if (b == SYM_OPEN) opens++;
      else if (b == SYM_CLOSE && opens > 0) opens--;
      send_word(OP_APPEND, b, rand_byte(), rand_eof());
    end
    while (opens > 0 && $urandom_range(5) != 0) begin
      send_word(OP_APPEND, SYM_CLOSE, rand_byte(), rand_eof());
      opens--;
    end
    steps = 0;
    while (steps < 100 && (sb.pc < sb.code_len || $urandom_range(7) == 0)) begin
      send_word(OP_STEP, rand_byte(), rand_byte(), rand_eof());
      steps++;
    end
  endtask

  // nest past the stack depth on a nonzero cell
  task automatic overflow_episode();
    int n;
    int i;
    n = STACK_DEPTH + $urandom_range(1, 4);
    send_word(OP_CLEAR, rand_byte(), rand_byte(), rand_eof());
    send_word(OP_APPEND, SYM_IN, rand_byte(), rand_eof());
    for (i = 0; i < n; i++) send_word(OP_APPEND, SYM_OPEN, rand_byte(), rand_eof());
    send_word(OP_APPEND, SYM_DEC, rand_byte(), rand_eof());
    send_word(OP_APPEND, SYM_CLOSE, rand_byte(), rand_eof());
    send_word(OP_APPEND, SYM_CLOSE, rand_byte(), rand_eof());
    send_word(OP_STEP, rand_byte(), 8'($urandom_range(1, 255)), 1'b0);
    for (i = 0; i < n + 8; i++) send_word(OP_STEP, rand_byte(), rand_byte(), rand_eof());
  endtask

  task automatic random_phase(int count);
    int  first;
    bit  restarted;
    op_t noise_op;
    first     = words_sent;
    restarted = 1'b0;
    overflow_episode();
    while (words_sent - first < count) begin
      if (!restarted && words_sent - first > count / 2) begin
        send_word(OP_RESTART, rand_byte(), rand_byte(), rand_eof());
        restarted = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          noise_op = op_t'(2'($urandom_range(3)));
          if (noise_op == OP_RESTART) noise_op = OP_STEP;
          send_word(noise_op, rand_byte(), rand_byte(), rand_eof());
        end
      end else begin
        program_episode();
      end
    end
  endtask

  initial begin
    int i;
    sb = new();
    send_idle_pct = 29;
    recv_idle_pct = 59;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-written program: eof read, wraps, underflow, skips
    send_word(OP_STEP, 8'h00, 8'hFF, 1'b0);
    for (i = 0; i < 14; i++) begin
      send_word(OP_APPEND, DEMO_CODE[8*(13-i) +: 8], 8'h00, 1'b1);
    end
    for (i = 0; i < 13; i++) begin
      send_word(OP_STEP, 8'hFF, (i == 4) ? 8'hA5 : 8'h5A, (i == 0));
    end
    send_word(OP_RESTART, 8'h00, 8'h00, 1'b0);
    send_word(OP_STEP, 8'h00, 8'h00, 1'b0);

    random_phase(400);

    send_idle_pct = 59;
    recv_idle_pct = 29;
    random_phase(400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(400);

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
